>>> rtl/core/undo_redo_history_buffer_assert.svh
// ---------------------------------------------------------------------------
// undo_redo_history_buffer_assert
// assertion macros for the undo/redo history buffer
// ---------------------------------------------------------------------------
`ifndef UNDO_REDO_HISTORY_BUFFER_ASSERT_SVH
`define UNDO_REDO_HISTORY_BUFFER_ASSERT_SVH

// consequent holds in the same cycle
`define URH_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("history buffer check failed");

// consequent holds in the next cycle
`define URH_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("history buffer sequencing check failed");

`endif

>>> rtl/core/urh_pkg.sv
// ---------------------------------------------------------------------------
// urh_pkg
// types and constants shared by the undo/redo history buffer
// ---------------------------------------------------------------------------
`default_nettype none

package urh_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_BITS  = 32;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);
  localparam int CAP_BITS   = 4;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(15);

  typedef enum logic [1:0] {
    CMD_SAVE = 2'd0,
    CMD_UNDO = 2'd1,
    CMD_REDO = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [WORD_BITS-1:0] entry_data;
    logic [ADDR_BITS-1:0] index;
  } request_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] data_out;
    logic                 valid_res;
    logic                 out_of_range;
    logic [CNT_BITS-1:0]  cursor_pos;
    logic [CNT_BITS-1:0]  stored_count;
  } response_t;

endpackage

`default_nettype wire

>>> rtl/core/undo_redo_history_buffer.sv
// latency: a result strobes on done in the cycle right after start is taken
// a new request is taken only in the idle state; start is ignored while busy
// busy is high for the one result cycle; the receiver cannot stall
// reset: synchronous rst empties the history, clears the cursor and sets capacity to 15
// the ring memory itself is not cleared; entries are only read below the count
// ---------------------------------------------------------------------------
// undo_redo_history_buffer
// bounded undo/redo history kept in a ring memory with a cursor
// ---------------------------------------------------------------------------
`default_nettype none

module undo_redo_history_buffer (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  output logic                              busy,
  input  wire  urh_pkg::request_t           request,
  output logic                              done,
  output urh_pkg::response_t                response,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [urh_pkg::CAP_BITS-1:0]      cfg_data
);

  localparam int AW = urh_pkg::ADDR_BITS;
  localparam int CW = urh_pkg::CNT_BITS;
  localparam int WW = urh_pkg::WORD_BITS;

  logic [WW-1:0] mem [urh_pkg::DEPTH];

  urh_pkg::state_t state, state_next;

  logic [CW-1:0]                count, count_next;
  logic [CW-1:0]                cursor, cursor_next;
  logic [AW-1:0]                oldest, oldest_next;
  logic [urh_pkg::CAP_BITS-1:0] capacity;

  logic [WW-1:0] rdata;
  logic [WW-1:0] res_word;
  logic          res_save;
  logic          res_valid;
  logic          res_oor;

  logic          accept;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          hit_valid;
  logic          hit_oor;

  logic [CW-1:0] c1, c2, cur1, cur_step, rpos;
  logic [AW-1:0] o1, o2;

  assign accept    = start && (state == urh_pkg::ST_IDLE);
  assign cfg_ready = (state == urh_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= urh_pkg::ST_IDLE;
      count    <= '0;
      cursor   <= '0;
      oldest   <= '0;
      capacity <= urh_pkg::CAP_RESET;
    end else begin
      state <= state_next;
      if (accept) begin
        count  <= count_next;
        cursor <= cursor_next;
        oldest <= oldest_next;
      end
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
    end
  end

  // result fields for the response cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      res_word  <= request.entry_data;
      res_save  <= (request.cmd == urh_pkg::CMD_SAVE);
      res_valid <= hit_valid;
      res_oor   <= hit_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= request.entry_data;
    end
    rdata <= mem[raddr];
  end

  // save path: evict if over capacity, truncate, evict again if the ring is full, append
  always_comb begin
    if (count > {1'b0, capacity}) begin
      o1   = oldest + AW'(1);
      c1   = count - CW'(1);
      cur1 = (cursor != '0) ? cursor - CW'(1) : '0;
    end else begin
      o1   = oldest;
      c1   = count;
      cur1 = cursor;
    end
    c2 = (cur1 < c1) ? cur1 : c1;
    o2 = o1;
    if (c2 >= CW'(urh_pkg::DEPTH)) begin
      o2 = o1 + AW'(1);
      c2 = c2 - CW'(1);
    end
  end

  always_comb begin
    if (request.cmd == urh_pkg::CMD_UNDO) begin
      cur_step = (cursor > CW'(1)) ? cursor - CW'(1) : cursor;
    end else begin
      cur_step = (cursor < count) ? cursor + CW'(1) : cursor;
    end
    rpos = cur_step - CW'(1);
  end

  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    oldest_next = oldest;
    mem_we      = 1'b0;
    waddr       = o2 + c2[AW-1:0];
    raddr       = oldest;
    hit_valid   = 1'b0;
    hit_oor     = 1'b0;
    unique case (request.cmd)
      urh_pkg::CMD_SAVE: begin
        mem_we      = accept;
        oldest_next = o2;
        count_next  = c2 + CW'(1);
        cursor_next = c2 + CW'(1);
        hit_valid   = 1'b1;
      end
      urh_pkg::CMD_READ: begin
        raddr = oldest + request.index;
        if (count != '0) begin
          if ({1'b0, request.index} < count) begin
            hit_valid = 1'b1;
          end else begin
            hit_oor = 1'b1;
          end
        end
      end
      urh_pkg::CMD_UNDO, urh_pkg::CMD_REDO: begin
        cursor_next = cur_step;
        raddr       = oldest + rpos[AW-1:0];
        if (count != '0) begin
          if ((cur_step != '0) && (rpos < count)) begin
            hit_valid = 1'b1;
          end else begin
            hit_oor = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      urh_pkg::ST_IDLE: if (accept) state_next = urh_pkg::ST_RESP;
      urh_pkg::ST_RESP: state_next = urh_pkg::ST_IDLE;
      default:          state_next = urh_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != urh_pkg::ST_IDLE);
  assign done = (state == urh_pkg::ST_RESP);

  always_comb begin
    response.data_out     = '0;
    if (res_valid) begin
      response.data_out   = res_save ? res_word : rdata;
    end
    response.valid_res    = res_valid;
    response.out_of_range = res_oor;
    response.cursor_pos   = cursor;
    response.stored_count = count;
  end

`include "undo_redo_history_buffer_assert.svh"

  `URH_ASSERT_NEXT(a_accept_done, clk, rst, accept, done && busy)
  `URH_ASSERT_NOW(a_count_max, clk, rst, done, response.stored_count <= CW'(urh_pkg::DEPTH))
  `URH_ASSERT_NOW(a_cursor_max, clk, rst, done, response.cursor_pos <= response.stored_count)
  `URH_ASSERT_NOW(a_invalid_zero, clk, rst, done && !response.valid_res, response.data_out == '0)
  `URH_ASSERT_NOW(a_flags_exclusive, clk, rst, done, !(response.valid_res && response.out_of_range))

endmodule

`default_nettype wire
